// ===== design/backfilled_moving_average_3ch_top_defines.svh =====
// ----------------------------------------------------------------------------
// bma3 assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BACKFILLED_MOVING_AVERAGE_3CH_TOP_DEFINES_SVH
`define BACKFILLED_MOVING_AVERAGE_3CH_TOP_DEFINES_SVH

`ifndef SYNTH
`define BMA3_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bma3 assertion failed");
`define BMA3_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bma3 forbidden condition");
`else
`define BMA3_ASSERT(lbl, clk, rstn, prop)
`define BMA3_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== design/bma3_pkg.sv =====
// ----------------------------------------------------------------------------
// bma3_pkg
// shared constants and types of the three-channel moving average
// ----------------------------------------------------------------------------
`default_nettype none

package bma3_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int WINDOW_RESET = 30;
  localparam int LANES        = 3;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = $clog2(WINDOW_MAX);
  localparam int W_W          = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W        = DATA_W + ADDR_W;
  localparam int CNT_W        = $clog2(SUM_W);
  localparam int RING_W       = LANES * DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_LOAD,
    ST_DIV,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic upd;
    logic sub;
    logic load;
    logic clr;
  } lane_ctl_t;

  typedef struct packed {
    logic [W_W-1:0] count;
    logic           eor;
    logic           tsh;
  } mrg_req_t;

endpackage

`default_nettype wire

// ===== design/bma3_lane.sv =====
// ----------------------------------------------------------------------------
// bma3_lane
// one channel: running window sum and bit-serial signed division by window
// ----------------------------------------------------------------------------
`default_nettype none

module bma3_lane (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire bma3_pkg::lane_ctl_t                   ctl_i,
  input  wire logic signed [bma3_pkg::DATA_W-1:0]    sample_i,
  input  wire logic signed [bma3_pkg::DATA_W-1:0]    old_i,
  input  wire logic        [bma3_pkg::W_W-1:0]       win_i,
  output logic                                       busy_o,
  output logic        [bma3_pkg::DATA_W-1:0]         mean_o
);

  localparam int SUM_W  = bma3_pkg::SUM_W;
  localparam int DATA_W = bma3_pkg::DATA_W;
  localparam int W_W    = bma3_pkg::W_W;
  localparam int CNT_W  = bma3_pkg::CNT_W;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W-1:0] smp_ext, old_ext;
  logic        [SUM_W-1:0] mag_q, mag_d;
  logic        [W_W-1:0]   rem_q, rem_d;
  logic        [CNT_W-1:0] cnt_q;
  logic                    busy_q;
  logic                    neg_q;
  logic        [W_W:0]     trial;
  logic        [W_W:0]     trial_sub;
  logic                    ge;
  logic        [DATA_W-1:0] quot;

  assign smp_ext = SUM_W'(sample_i);
  assign old_ext = ctl_i.sub ? SUM_W'(old_i) : '0;

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.clr) begin
      sum_d = '0;
    end else if (ctl_i.upd) begin
      sum_d = sum_q - old_ext + smp_ext;
    end
  end

  // restoring division step on the magnitude
  assign trial     = {rem_q, mag_q[SUM_W-1]};
  assign ge        = trial >= {1'b0, win_i};
  assign trial_sub = trial - {1'b0, win_i};
  assign rem_d     = ge ? trial_sub[W_W-1:0] : trial[W_W-1:0];
  assign mag_d     = {mag_q[SUM_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      sum_q <= sum_d;
      if (ctl_i.load) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      neg_q <= sum_q[SUM_W-1];
      mag_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  assign quot   = mag_q[DATA_W-1:0];
  assign mean_o = neg_q ? (~quot + 1'b1) : quot;
  assign busy_o = busy_q;

endmodule

`default_nettype wire

// ===== design/bma3_merge.sv =====
// ----------------------------------------------------------------------------
// bma3_merge
// joins the lane means into one result word and repeats it for back-fill
// ----------------------------------------------------------------------------
`default_nettype none

module bma3_merge (
  input  wire logic                                                clk_i,
  input  wire logic                                                rst_ni,
  input  wire logic                                                push_i,
  input  wire bma3_pkg::mrg_req_t                                  req_i,
  input  wire logic [bma3_pkg::LANES-1:0][bma3_pkg::DATA_W-1:0]    mean_i,
  output logic                                                     rdy_o,
  output logic                                                     m_axis_tvalid,
  input  wire logic                                                m_axis_tready,
  // mean_x, mean_y, mean_angle
  output logic [bma3_pkg::RING_W-1:0]                              m_axis_tdata,
  output logic                                                     m_axis_tlast,
  // too_short
  output logic [0:0]                                               m_axis_tuser
);

  localparam int W_W = bma3_pkg::W_W;

  logic                          valid_q;
  logic [W_W-1:0]                rem_q;
  logic                          eor_q;
  logic                          last_q;
  logic [bma3_pkg::RING_W-1:0]   data_q;
  logic                          tsh_q;
  logic                          out_xfer;

  assign out_xfer = valid_q && m_axis_tready;
  assign rdy_o    = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
      eor_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      if (push_i) begin
        valid_q <= 1'b1;
        rem_q   <= req_i.count;
        eor_q   <= req_i.eor;
        last_q  <= req_i.eor && (req_i.count == W_W'(1));
      end else if (out_xfer) begin
        if (rem_q > W_W'(1)) begin
          rem_q  <= rem_q - 1'b1;
          last_q <= eor_q && (rem_q == W_W'(2));
        end else begin
          valid_q <= 1'b0;
          rem_q   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= req_i.tsh ? '0 : mean_i;
      tsh_q  <= req_i.tsh;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = tsh_q;

endmodule

`default_nettype wire

// ===== design/backfilled_moving_average_3ch_top.sv =====
// each sample passes IDLE, UPD and, if it gives results, LOAD, DIV and PUSH (waits for merge ready)
// s_axis_tready is high only in IDLE, so no new sample is taken until the last one is through
// DIV is set by the 38-step bit-serial divider, one per channel, all run in parallel
// a window-completing sample gives window_len results, one per cycle while m_axis_tready holds
// reset: asynchronous, active low; window length 30, sums and counts cleared, ring not cleared
// ----------------------------------------------------------------------------
// backfilled_moving_average_3ch_top
// back-filled three-channel moving average over a sample ring
// ----------------------------------------------------------------------------
`default_nettype none

`include "backfilled_moving_average_3ch_top_defines.svh"

module backfilled_moving_average_3ch_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_wen_i,
  input  wire logic [bma3_pkg::W_W-1:0]          cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // shift_x, shift_y, angle
  input  wire logic [bma3_pkg::RING_W-1:0]       s_axis_tdata,
  // final_sample
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // mean_x, mean_y, mean_angle
  output logic [bma3_pkg::RING_W-1:0]            m_axis_tdata,
  output logic                                   m_axis_tlast,
  // too_short
  output logic [0:0]                             m_axis_tuser
);

  localparam int LANES      = bma3_pkg::LANES;
  localparam int DATA_W     = bma3_pkg::DATA_W;
  localparam int ADDR_W     = bma3_pkg::ADDR_W;
  localparam int W_W        = bma3_pkg::W_W;
  localparam int RING_W     = bma3_pkg::RING_W;
  localparam int WINDOW_MAX = bma3_pkg::WINDOW_MAX;

  bma3_pkg::state_e    st_q, st_d;
  bma3_pkg::lane_ctl_t lane_ctl;
  bma3_pkg::mrg_req_t  req_q, req_d;

  logic [RING_W-1:0]  ring_mem [WINDOW_MAX];
  logic [RING_W-1:0]  rd_q;
  logic [RING_W-1:0]  smp_q;
  logic               fin_q;
  logic               full_q;
  logic [W_W-1:0]     weff_q;
  logic [W_W-1:0]     weff_d;
  logic [W_W-1:0]     fill_q;
  logic [ADDR_W-1:0]  slot_q;
  logic [W_W-1:0]     slot_ext;
  logic [W_W-1:0]     slot_inc;
  logic [W_W-1:0]     fill_inc;
  logic               first;
  logic               emit;
  logic               in_xfer;
  logic               ring_we;
  logic               push;
  logic               mrg_rdy;
  logic [LANES-1:0]   lane_busy;
  logic [LANES-1:0][DATA_W-1:0] lane_mean;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign slot_ext = W_W'(slot_q);
  assign slot_inc = slot_ext + 1'b1;
  assign fill_inc = fill_q + 1'b1;
  assign first    = !full_q && (fill_inc == weff_q);
  assign emit     = full_q || first || fin_q;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      weff_d = W_W'(1);
    end else if (cfg_wdata_i > W_W'(WINDOW_MAX)) begin
      weff_d = W_W'(WINDOW_MAX);
    end else begin
      weff_d = cfg_wdata_i;
    end
  end

  always_comb begin
    req_d.count = full_q ? W_W'(1) : (first ? weff_q : W_W'(1));
    req_d.eor   = fin_q;
    req_d.tsh   = !full_q && !first;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      bma3_pkg::ST_IDLE: begin
        if (in_xfer) st_d = bma3_pkg::ST_UPD;
      end
      bma3_pkg::ST_UPD: begin
        st_d = emit ? bma3_pkg::ST_LOAD : bma3_pkg::ST_IDLE;
      end
      bma3_pkg::ST_LOAD: begin
        st_d = bma3_pkg::ST_DIV;
      end
      bma3_pkg::ST_DIV: begin
        if (lane_busy == '0) st_d = bma3_pkg::ST_PUSH;
      end
      bma3_pkg::ST_PUSH: begin
        if (mrg_rdy) st_d = bma3_pkg::ST_IDLE;
      end
      default: begin
        st_d = bma3_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = (st_q == bma3_pkg::ST_IDLE);
    ring_we       = (st_q == bma3_pkg::ST_UPD);
    push          = (st_q == bma3_pkg::ST_PUSH) && mrg_rdy;
    lane_ctl.upd  = (st_q == bma3_pkg::ST_UPD);
    lane_ctl.sub  = full_q;
    lane_ctl.load = (st_q == bma3_pkg::ST_LOAD);
    lane_ctl.clr  = ((st_q == bma3_pkg::ST_LOAD) && fin_q) || cfg_wen_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= bma3_pkg::ST_IDLE;
      weff_q <= W_W'(bma3_pkg::WINDOW_RESET);
      fill_q <= '0;
      slot_q <= '0;
      full_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_wen_i) begin
        weff_q <= weff_d;
        fill_q <= '0;
        slot_q <= '0;
      end else if (st_q == bma3_pkg::ST_UPD) begin
        if (fin_q) begin
          fill_q <= '0;
          slot_q <= '0;
        end else begin
          slot_q <= (slot_inc >= weff_q) ? '0 : slot_inc[ADDR_W-1:0];
          if (!full_q) fill_q <= fill_inc;
        end
      end
      if (in_xfer) begin
        full_q <= fill_q >= weff_q;
        fin_q  <= s_axis_tlast;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      smp_q <= s_axis_tdata;
    end
    if (st_q == bma3_pkg::ST_UPD) begin
      req_q <= req_d;
    end
  end

  // sample ring, read on transfer, written back in the update cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= ring_mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_q] <= smp_q;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bma3_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .sample_i (smp_q[g*DATA_W +: DATA_W]),
      .old_i    (rd_q[g*DATA_W +: DATA_W]),
      .win_i    (weff_q),
      .busy_o   (lane_busy[g]),
      .mean_o   (lane_mean[g])
    );
  end

  bma3_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .req_i         (req_q),
    .mean_i        (lane_mean),
    .rdy_o         (mrg_rdy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `BMA3_ASSERT(a_slot_in_window, clk_i, rst_ni, slot_ext < weff_q)
  `BMA3_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= weff_q)
  `BMA3_ASSERT(a_lanes_lockstep, clk_i, rst_ni, (lane_busy == '0) || (lane_busy == '1))
  `BMA3_ASSERT(a_load_starts_div, clk_i, rst_ni, (st_q == bma3_pkg::ST_LOAD) |=> (lane_busy == '1))
  `BMA3_NEVER(a_push_while_full, clk_i, rst_ni, push && m_axis_tvalid)

endmodule

`default_nettype wire
